### hdl/wtsp_pkg.sv
// Shared types and constants of the world-to-screen projection unit.
package wtsp_pkg;

    localparam int CFG_W    = 64;
    localparam int DIM_W    = 14;
    localparam int COORD_W  = 32;
    localparam int IDX_W    = 3;
    localparam int QBITS    = 41;
    localparam int OFF_EXP  = 40;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW0_A = 3'd0,
        REG_ROW0_B = 3'd1,
        REG_ROW1_A = 3'd2,
        REG_ROW1_B = 3'd3,
        REG_ROW3_A = 3'd4,
        REG_ROW3_B = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } wtsp_reg_t;

    typedef struct packed {
        logic valid;
        logic visible;
        logic ovf_x;
        logic ovf_y;
        logic neg_x;
        logic neg_y;
    } wtsp_ctrl_t;

endpackage

### hdl/wtsp_dot.sv
// Two-stage pipelined dot product of one matrix row with a world point.
module wtsp_dot
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int DOT_W     = 50
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [COORD_W-1:0]  px,
    input  logic signed [COORD_W-1:0]  py,
    input  logic signed [COORD_W-1:0]  pz,
    input  logic signed [COORD_W-1:0]  m0,
    input  logic signed [COORD_W-1:0]  m1,
    input  logic signed [COORD_W-1:0]  m2,
    input  logic signed [COORD_W-1:0]  m3,
    output logic signed [DOT_W-1:0]    dot
);

    logic signed [2*COORD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [COORD_W-1:0]   m3_reg;
    logic signed [DOT_W-1:0]     dot_reg, dot_next;

    always_comb begin
        dot_next = DOT_W'(p0_reg >>> FRAC_BITS) + DOT_W'(p1_reg >>> FRAC_BITS)
                 + DOT_W'(p2_reg >>> FRAC_BITS) + DOT_W'(m3_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg  <= m0 * px;
            p1_reg  <= m1 * py;
            p2_reg  <= m2 * pz;
            m3_reg  <= m3;
            dot_reg <= dot_next;
        end
    end

    assign dot = dot_reg;

endmodule

### hdl/wtsp_div_step.sv
// One restoring division step for both screen axes, sharing the divisor w.
module wtsp_div_step
    import wtsp_pkg::*;
#(
    parameter int NUM_W = 79,
    parameter int DOT_W = 50,
    parameter int SHIFT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  wtsp_ctrl_t         ctrl_in,
    input  logic [DOT_W-1:0]   w_in,
    input  logic [NUM_W-1:0]   rem_x_in,
    input  logic [NUM_W-1:0]   rem_y_in,
    input  logic [QBITS-1:0]   q_x_in,
    input  logic [QBITS-1:0]   q_y_in,
    output wtsp_ctrl_t         ctrl_out,
    output logic [DOT_W-1:0]   w_out,
    output logic [NUM_W-1:0]   rem_x_out,
    output logic [NUM_W-1:0]   rem_y_out,
    output logic [QBITS-1:0]   q_x_out,
    output logic [QBITS-1:0]   q_y_out
);

    localparam int CW = DOT_W + QBITS;

    wtsp_ctrl_t        ctrl_reg;
    logic [DOT_W-1:0]  w_reg;
    logic [NUM_W-1:0]  rx_reg, ry_reg, rx_next, ry_next;
    logic [QBITS-1:0]  qx_reg, qy_reg;
    logic [CW-1:0]     dsh;
    logic              bx, by;

    always_comb begin
        dsh     = CW'(w_in) << SHIFT;
        bx      = CW'(rem_x_in) >= dsh;
        by      = CW'(rem_y_in) >= dsh;
        rx_next = bx ? NUM_W'(CW'(rem_x_in) - dsh) : rem_x_in;
        ry_next = by ? NUM_W'(CW'(rem_y_in) - dsh) : rem_y_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= ctrl_in.valid;
        end
        if (en) begin
            ctrl_reg.visible <= ctrl_in.visible;
            ctrl_reg.ovf_x   <= ctrl_in.ovf_x;
            ctrl_reg.ovf_y   <= ctrl_in.ovf_y;
            ctrl_reg.neg_x   <= ctrl_in.neg_x;
            ctrl_reg.neg_y   <= ctrl_in.neg_y;
            w_reg            <= w_in;
            rx_reg           <= rx_next;
            ry_reg           <= ry_next;
            qx_reg           <= {q_x_in[QBITS-2:0], bx};
            qy_reg           <= {q_y_in[QBITS-2:0], by};
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign w_out     = w_reg;
    assign rem_x_out = rx_reg;
    assign rem_y_out = ry_reg;
    assign q_x_out   = qx_reg;
    assign q_y_out   = qy_reg;

endmodule

### hdl/world_to_screen_projection_unit.sv
// Top level of the world-to-screen projection unit.
// One point is taken per cycle while the output is not stalled, and passes through the
// dot products, magnitude scaling and range check, 41 restoring division
// steps (one quotient bit each, both axes in parallel) and viewport mapping
// into the output register. All stages advance together, so a stalled result holds
// the whole pipeline and the input is ready whenever the output register can move.
module world_to_screen_projection_unit
    import wtsp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [95:0]        s_tdata,   // point_x, point_y, point_z
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,   // visible, pixel_x, pixel_y, zero fill
    input  logic               cfg_wen,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_wdata
);

    localparam int DOT_W = 66 - FRAC_BITS;
    localparam int PRD_W = DOT_W + DIM_W;
    localparam int NUM_W = PRD_W + FRAC_BITS - 1;
    localparam int CW    = DOT_W + QBITS;
    localparam int SUM_W = OFF_EXP + 8;
    localparam logic signed [DOT_W-1:0] W_MIN =
        DOT_W'(((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);

    logic [CFG_W-1:0] cfg_reg [0:5];
    logic [DIM_W-1:0] wd_reg, ht_reg;
    logic             adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[REG_ROW0_A] <= 64'd65536;
            cfg_reg[REG_ROW0_B] <= 64'd0;
            cfg_reg[REG_ROW1_A] <= 64'd65536 << 32;
            cfg_reg[REG_ROW1_B] <= 64'd0;
            cfg_reg[REG_ROW3_A] <= 64'd0;
            cfg_reg[REG_ROW3_B] <= 64'd65536;
            wd_reg              <= 14'd1920;
            ht_reg              <= 14'd1080;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_WIDTH:  wd_reg <= cfg_wdata[DIM_W-1:0];
                REG_HEIGHT: ht_reg <= cfg_wdata[DIM_W-1:0];
                default:    cfg_reg[cfg_index] <= cfg_wdata;
            endcase
        end
    end

    assign adv      = m_tready || !m_tvalid;
    assign s_tready = adv;

    logic signed [COORD_W-1:0] in_x, in_y, in_z;
    assign in_x = s_tdata[31:0];
    assign in_y = s_tdata[63:32];
    assign in_z = s_tdata[95:64];

    logic signed [DOT_W-1:0] cx, cy, cw;

    wtsp_dot #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_dot_x (
        .aclk(aclk), .en(adv), .px(in_x), .py(in_y), .pz(in_z),
        .m0(cfg_reg[REG_ROW0_A][31:0]), .m1(cfg_reg[REG_ROW0_A][63:32]),
        .m2(cfg_reg[REG_ROW0_B][31:0]), .m3(cfg_reg[REG_ROW0_B][63:32]), .dot(cx)
    );
    wtsp_dot #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_dot_y (
        .aclk(aclk), .en(adv), .px(in_x), .py(in_y), .pz(in_z),
        .m0(cfg_reg[REG_ROW1_A][31:0]), .m1(cfg_reg[REG_ROW1_A][63:32]),
        .m2(cfg_reg[REG_ROW1_B][31:0]), .m3(cfg_reg[REG_ROW1_B][63:32]), .dot(cy)
    );
    wtsp_dot #(.FRAC_BITS(FRAC_BITS), .DOT_W(DOT_W)) u_dot_w (
        .aclk(aclk), .en(adv), .px(in_x), .py(in_y), .pz(in_z),
        .m0(cfg_reg[REG_ROW3_A][31:0]), .m1(cfg_reg[REG_ROW3_A][63:32]),
        .m2(cfg_reg[REG_ROW3_B][31:0]), .m3(cfg_reg[REG_ROW3_B][63:32]), .dot(cw)
    );

    logic v1_reg, v2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
        end
    end

    wtsp_ctrl_t        c3_reg, c4_reg, c3_next, c4_next;
    logic [PRD_W-1:0]  nx3_reg, ny3_reg;
    logic [DOT_W-1:0]  w3_reg, w4_reg;
    logic [NUM_W-1:0]  nx4_reg, ny4_reg, nx4_next, ny4_next;
    logic [DOT_W-1:0]  magx, magy;
    logic [CW-1:0]     wlim;

    always_comb begin
        magx            = cx[DOT_W-1] ? DOT_W'(-cx) : DOT_W'(cx);
        magy            = cy[DOT_W-1] ? DOT_W'(-cy) : DOT_W'(cy);
        c3_next.valid   = v2_reg;
        c3_next.visible = cw >= W_MIN;
        c3_next.neg_x   = cx[DOT_W-1];
        c3_next.neg_y   = cy[DOT_W-1];
        c3_next.ovf_x   = 1'b0;
        c3_next.ovf_y   = 1'b0;
        nx4_next        = NUM_W'(nx3_reg) << (FRAC_BITS - 1);
        ny4_next        = NUM_W'(ny3_reg) << (FRAC_BITS - 1);
        wlim            = CW'(w3_reg) << QBITS;
        c4_next         = c3_reg;
        c4_next.ovf_x   = CW'(nx4_next) >= wlim;
        c4_next.ovf_y   = CW'(ny4_next) >= wlim;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c3_reg.valid <= 1'b0;
            c4_reg.valid <= 1'b0;
        end else if (adv) begin
            c3_reg.valid <= c3_next.valid;
            c4_reg.valid <= c4_next.valid;
        end
        if (adv) begin
            c3_reg.visible <= c3_next.visible;
            c3_reg.neg_x   <= c3_next.neg_x;
            c3_reg.neg_y   <= c3_next.neg_y;
            c3_reg.ovf_x   <= c3_next.ovf_x;
            c3_reg.ovf_y   <= c3_next.ovf_y;
            nx3_reg        <= PRD_W'(magx) * PRD_W'(wd_reg);
            ny3_reg        <= PRD_W'(magy) * PRD_W'(ht_reg);
            w3_reg         <= DOT_W'(cw);
            c4_reg.visible <= c4_next.visible;
            c4_reg.neg_x   <= c4_next.neg_x;
            c4_reg.neg_y   <= c4_next.neg_y;
            c4_reg.ovf_x   <= c4_next.ovf_x;
            c4_reg.ovf_y   <= c4_next.ovf_y;
            nx4_reg        <= nx4_next;
            ny4_reg        <= ny4_next;
            w4_reg         <= w3_reg;
        end
    end

    wtsp_ctrl_t       dc   [0:QBITS];
    logic [DOT_W-1:0] dw   [0:QBITS];
    logic [NUM_W-1:0] drx  [0:QBITS];
    logic [NUM_W-1:0] dry  [0:QBITS];
    logic [QBITS-1:0] dqx  [0:QBITS];
    logic [QBITS-1:0] dqy  [0:QBITS];

    assign dc[0]  = c4_reg;
    assign dw[0]  = w4_reg;
    assign drx[0] = nx4_reg;
    assign dry[0] = ny4_reg;
    assign dqx[0] = '0;
    assign dqy[0] = '0;

    for (genvar i = 0; i < QBITS; i++) begin : g_div
        wtsp_div_step #(.NUM_W(NUM_W), .DOT_W(DOT_W), .SHIFT(QBITS - 1 - i)) u_step (
            .aclk(aclk), .aresetn(aresetn), .en(adv),
            .ctrl_in(dc[i]), .w_in(dw[i]), .rem_x_in(drx[i]), .rem_y_in(dry[i]),
            .q_x_in(dqx[i]), .q_y_in(dqy[i]),
            .ctrl_out(dc[i+1]), .w_out(dw[i+1]), .rem_x_out(drx[i+1]),
            .rem_y_out(dry[i+1]), .q_x_out(dqx[i+1]), .q_y_out(dqy[i+1])
        );
    end

    localparam logic [QBITS-1:0] OFF_LIMIT = QBITS'(1) << OFF_EXP;

    wtsp_ctrl_t               cf;
    logic [QBITS-1:0]         offx, offy;
    logic signed [SUM_W-1:0]  sx, sy;
    logic signed [COORD_W-1:0] pxs, pys;
    logic                     out_valid_reg;
    logic [64:0]              out_data_reg;

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi, lo;
        hi = SUM_W'(32'sh7FFF_FFFF);
        lo = SUM_W'(-64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return COORD_W'(v);
    endfunction

    always_comb begin
        cf   = dc[QBITS];
        offx = (cf.ovf_x || dqx[QBITS] > OFF_LIMIT) ? OFF_LIMIT : dqx[QBITS];
        offy = (cf.ovf_y || dqy[QBITS] > OFF_LIMIT) ? OFF_LIMIT : dqy[QBITS];
        sx   = (SUM_W'(wd_reg) <<< (FRAC_BITS - 1));
        sy   = (SUM_W'(ht_reg) <<< (FRAC_BITS - 1));
        sx   = cf.neg_x ? sx - SUM_W'(offx) : sx + SUM_W'(offx);
        sy   = cf.neg_y ? sy + SUM_W'(offy) : sy - SUM_W'(offy);
        pxs  = cf.visible ? sat(sx) : '0;
        pys  = cf.visible ? sat(sy) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= cf.valid;
        end
        if (adv) begin
            out_data_reg <= {pys, pxs, cf.visible};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (m_tready || !m_tvalid))
        else $error("Input ready does not follow the output stall.");
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == 64'd0)
        else $error("A hidden point carries non-zero pixels.");
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("A result is shown straight after reset.");

endmodule
